// ===== design/i2c_rrm_pkg.sv =====
// Shared types and constants for the I2C register read master.
package i2c_rrm_pkg;

  localparam int DEV_ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int TDATA_IN_W = 16;
  localparam int TDATA_OUT_W = 16;

  // Seven-bit target address after reset (write byte 0xD0).
  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'h68;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    STEP_IDLE    = 4'd0,
    STEP_START   = 4'd1,
    STEP_DEV_W   = 4'd2,
    STEP_REG     = 4'd3,
    STEP_RESTART = 4'd4,
    STEP_DEV_R   = 4'd5,
    STEP_READ    = 4'd6,
    STEP_NACK    = 4'd7,
    STEP_STOP    = 4'd8
  } step_t;

  typedef enum logic {
    MODE_TICK    = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_t;

  typedef struct packed {
    logic              ack_error;
    logic [BYTE_W-1:0] read_data;
    logic              data_valid;
    logic              busy_res;
    logic              sda_out;
    logic              scl_out;
  } result_t;

endpackage

// ===== design/i2c_rrm_seq.sv =====
// Bus sequencer: state registers and the per-transaction next-state logic.
module i2c_rrm_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [i2c_rrm_pkg::DEV_ADDR_W-1:0]   cfg_wr_data,
  input  logic                                 in_accept,
  input  logic                                 mode,
  input  logic [i2c_rrm_pkg::BYTE_W-1:0]       reg_address,
  input  logic                                 sda_in,
  output i2c_rrm_pkg::result_t                 res
);

  logic [i2c_rrm_pkg::DEV_ADDR_W-1:0] device_address;
  i2c_rrm_pkg::step_t                 step, step_next;
  logic [3:0]                         bit_count, bit_count_next;
  logic [1:0]                         half_phase, half_phase_next;
  logic [i2c_rrm_pkg::BYTE_W-1:0]     shift_byte, shift_byte_next;
  logic [i2c_rrm_pkg::BYTE_W-1:0]     register_latch, register_latch_next;
  logic                               nack_seen, nack_seen_next;
  logic                               scl_level, scl_level_next;
  logic                               sda_level, sda_level_next;
  logic                               valid;
  logic                               bitv;
  logic [3:0]                         bit_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2c_rrm_pkg::DEV_ADDR_RESET;
    end else if (cfg_wr_en) begin
      device_address <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= i2c_rrm_pkg::STEP_IDLE;
      bit_count      <= '0;
      half_phase     <= '0;
      shift_byte     <= '0;
      register_latch <= '0;
      nack_seen      <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
    end else if (in_accept) begin
      step           <= step_next;
      bit_count      <= bit_count_next;
      half_phase     <= half_phase_next;
      shift_byte     <= shift_byte_next;
      register_latch <= register_latch_next;
      nack_seen      <= nack_seen_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
    end
  end

  always_comb begin
    step_next           = step;
    bit_count_next      = bit_count;
    half_phase_next     = half_phase;
    shift_byte_next     = shift_byte;
    register_latch_next = register_latch;
    nack_seen_next      = nack_seen;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    valid               = 1'b0;
    bitv    = (bit_count < i2c_rrm_pkg::BITS_PER_BYTE) ? shift_byte[i2c_rrm_pkg::BYTE_W-1] : 1'b1;
    bit_inc = bit_count + 4'd1;

    if (mode == i2c_rrm_pkg::MODE_REQUEST) begin
      // A request while a sequence runs is dropped without any change.
      if (step == i2c_rrm_pkg::STEP_IDLE) begin
        register_latch_next = reg_address;
        nack_seen_next      = 1'b0;
        step_next           = i2c_rrm_pkg::STEP_START;
        half_phase_next     = '0;
        bit_count_next      = '0;
        shift_byte_next     = '0;
      end
    end else begin
      unique case (step)
        i2c_rrm_pkg::STEP_START, i2c_rrm_pkg::STEP_RESTART: begin
          case (half_phase)
            2'd0: begin
              scl_level_next = 1'b0; sda_level_next = 1'b1; half_phase_next = 2'd1;
            end
            2'd1: begin
              scl_level_next = 1'b1; sda_level_next = 1'b1; half_phase_next = 2'd2;
            end
            2'd2: begin
              scl_level_next = 1'b1; sda_level_next = 1'b0; half_phase_next = 2'd3;
            end
            default: begin
              scl_level_next  = 1'b0;
              sda_level_next  = 1'b0;
              half_phase_next = '0;
              bit_count_next  = '0;
              if (step == i2c_rrm_pkg::STEP_START) begin
                step_next       = i2c_rrm_pkg::STEP_DEV_W;
                shift_byte_next = {device_address, 1'b0};
              end else begin
                step_next       = i2c_rrm_pkg::STEP_DEV_R;
                shift_byte_next = {device_address, 1'b1};
              end
            end
          endcase
        end
        i2c_rrm_pkg::STEP_DEV_W, i2c_rrm_pkg::STEP_REG, i2c_rrm_pkg::STEP_DEV_R: begin
          if (half_phase == 2'd0) begin
            scl_level_next  = 1'b0;
            sda_level_next  = bitv;
            half_phase_next = 2'd1;
          end else begin
            scl_level_next  = 1'b1;
            sda_level_next  = bitv;
            half_phase_next = '0;
            if (bit_count >= i2c_rrm_pkg::BITS_PER_BYTE) begin
              // Acknowledge clock: a high level means the target did not answer.
              if (sda_in) begin
                nack_seen_next = 1'b1;
              end
              bit_count_next = '0;
              if (step == i2c_rrm_pkg::STEP_DEV_W) begin
                step_next       = i2c_rrm_pkg::STEP_REG;
                shift_byte_next = register_latch;
              end else if (step == i2c_rrm_pkg::STEP_REG) begin
                step_next       = i2c_rrm_pkg::STEP_RESTART;
                shift_byte_next = '0;
              end else begin
                step_next       = i2c_rrm_pkg::STEP_READ;
                shift_byte_next = '0;
              end
            end else begin
              shift_byte_next = {shift_byte[i2c_rrm_pkg::BYTE_W-2:0], 1'b0};
              bit_count_next  = bit_inc;
            end
          end
        end
        i2c_rrm_pkg::STEP_READ: begin
          scl_level_next = (half_phase != 2'd0);
          sda_level_next = 1'b1;
          if (half_phase == 2'd0) begin
            half_phase_next = 2'd1;
          end else begin
            half_phase_next = '0;
            shift_byte_next = {shift_byte[i2c_rrm_pkg::BYTE_W-2:0], sda_in};
            if (bit_inc >= i2c_rrm_pkg::BITS_PER_BYTE) begin
              step_next      = i2c_rrm_pkg::STEP_NACK;
              bit_count_next = '0;
            end else begin
              bit_count_next = bit_inc;
            end
          end
        end
        i2c_rrm_pkg::STEP_NACK: begin
          scl_level_next = (half_phase != 2'd0);
          sda_level_next = 1'b1;
          if (half_phase == 2'd0) begin
            half_phase_next = 2'd1;
          end else begin
            half_phase_next = '0;
            step_next       = i2c_rrm_pkg::STEP_STOP;
          end
        end
        i2c_rrm_pkg::STEP_STOP: begin
          if (half_phase == 2'd0) begin
            scl_level_next = 1'b0; sda_level_next = 1'b0; half_phase_next = 2'd1;
          end else if (half_phase == 2'd1) begin
            scl_level_next = 1'b1; sda_level_next = 1'b0; half_phase_next = 2'd2;
          end else begin
            scl_level_next  = 1'b1;
            sda_level_next  = 1'b1;
            half_phase_next = '0;
            step_next       = i2c_rrm_pkg::STEP_IDLE;
            valid           = 1'b1;
          end
        end
        default: begin
          // Idle and any unused step code park the bus released.
          step_next       = i2c_rrm_pkg::STEP_IDLE;
          half_phase_next = '0;
          bit_count_next  = '0;
          scl_level_next  = 1'b1;
          sda_level_next  = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_out    = scl_level_next;
    res.sda_out    = sda_level_next;
    res.busy_res   = (step_next != i2c_rrm_pkg::STEP_IDLE);
    res.data_valid = valid;
    res.read_data  = valid ? shift_byte_next : '0;
    res.ack_error  = nack_seen_next;
  end

`ifndef SYNTHESIS
  a_valid_from_stop: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res.data_valid) |-> (step == i2c_rrm_pkg::STEP_STOP && half_phase == 2'd2))
    else $error("data_valid raised outside the last stop phase");

  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode && step == i2c_rrm_pkg::STEP_IDLE)
      |=> (step == i2c_rrm_pkg::STEP_START && half_phase == 2'd0 && !nack_seen))
    else $error("accepted request did not start a clean sequence");

  a_two_phase_steps: assert property (@(posedge clk) disable iff (rst)
    (step == i2c_rrm_pkg::STEP_DEV_W || step == i2c_rrm_pkg::STEP_REG ||
     step == i2c_rrm_pkg::STEP_DEV_R || step == i2c_rrm_pkg::STEP_READ ||
     step == i2c_rrm_pkg::STEP_NACK) |-> (half_phase <= 2'd1))
    else $error("half phase out of range for a bit step");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= i2c_rrm_pkg::BITS_PER_BYTE)
    else $error("bit counter ran past one byte");
`endif

endmodule

// ===== design/i2c_rrm_out_buf.sv =====
// Output register with a skid stage between the sequencer and the result stream.
module i2c_rrm_out_buf (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic [i2c_rrm_pkg::TDATA_OUT_W-1:0]   push_data,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [i2c_rrm_pkg::TDATA_OUT_W-1:0]   out_data
);

  logic                                skid_valid;
  logic [i2c_rrm_pkg::TDATA_OUT_W-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== design/i2c_register_read_master_core.sv =====
// An accepted result is registered in the output register, or in the skid stage if that one stalls.
// One input transaction per cycle is taken; each yields exactly one result.
// Input stalls only while both the output register and the skid stage hold a result.
// Synchronous reset: idle sequencer, lines released, device address 0x68.
// Top level of the I2C register read master.
module i2c_register_read_master_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [i2c_rrm_pkg::DEV_ADDR_W-1:0]   cfg_wr_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [i2c_rrm_pkg::TDATA_IN_W-1:0]   s_axis_tdata,  // reg_address[7:0], sda_in[8]
  input  logic                                 s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], data_valid[3], read_data[11:4], ack_error[12]
  output logic [i2c_rrm_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);

  logic                                in_accept;
  i2c_rrm_pkg::result_t                res;
  logic [i2c_rrm_pkg::TDATA_OUT_W-1:0] res_data;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign res_data = {{(i2c_rrm_pkg::TDATA_OUT_W - $bits(i2c_rrm_pkg::result_t)){1'b0}}, res};

  i2c_rrm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .mode        (s_axis_tuser),
    .reg_address (s_axis_tdata[7:0]),
    .sda_in      (s_axis_tdata[8]),
    .res         (res)
  );

  i2c_rrm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (res_data),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the I2C register read master core.
module testbench;

  typedef struct packed {
    i2c_rrm_pkg::mode_t mode;
    logic [7:0]         reg_addr;
    logic               sda_in;
    logic               typed;   // 1 = expected lines below are used instead of the predictor
    logic               e_scl;
    logic               e_sda;
    logic               e_busy;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_wr_en = 1'b0;
  logic [i2c_rrm_pkg::DEV_ADDR_W-1:0] cfg_wr_data = '0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [i2c_rrm_pkg::TDATA_IN_W-1:0] s_axis_tdata = '0;  // reg_address[7:0], sda_in[8]
  logic                               s_axis_tuser = 1'b0;  // mode
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  // scl_out[0], sda_out[1], busy_res[2], data_valid[3], read_data[11:4], ack_error[12]
  logic [i2c_rrm_pkg::TDATA_OUT_W-1:0] m_axis_tdata;

  // Bus sequencer as the testbench expects it to behave.
  i2c_rrm_pkg::step_t                 bus_step;
  logic [3:0]                         bus_bits;
  logic [1:0]                         bus_phase;
  logic [7:0]                         bus_shift;
  logic [7:0]                         bus_reg;
  logic                               bus_nack;
  logic                               bus_scl;
  logic                               bus_sda;
  logic [i2c_rrm_pkg::DEV_ADDR_W-1:0] bus_dev;

  i2c_rrm_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      burst_left = 0;
  int      ready_left = 0;
  int      ready_style = 0;

  // Directed part: idle tick, request, request while busy, the start condition and
  // the default device byte, then a missing acknowledge.
  stim_row_t dir_rows [26] = '{
    '{i2c_rrm_pkg::MODE_TICK,    8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{i2c_rrm_pkg::MODE_REQUEST, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_REQUEST, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
    '{i2c_rrm_pkg::MODE_TICK,    8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_REQUEST, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{i2c_rrm_pkg::MODE_TICK,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  i2c_register_read_master_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic void set_lines(input logic scl, input logic sda);
    bus_scl = scl;
    bus_sda = sda;
  endfunction

  function automatic void enter_step(input i2c_rrm_pkg::step_t step, input logic [7:0] load);
    bus_step = step;
    bus_phase = '0;
    bus_bits = '0;
    bus_shift = load;
  endfunction

  // Start and repeated start; returns 1 on the last of the four phases.
  function automatic logic start_cond_tick();
    case (bus_phase)
      2'd0: set_lines(1'b0, 1'b1);
      2'd1: set_lines(1'b1, 1'b1);
      2'd2: set_lines(1'b1, 1'b0);
      default: begin
        set_lines(1'b0, 1'b0);
        return 1'b1;
      end
    endcase
    bus_phase = bus_phase + 2'd1;
    return 1'b0;
  endfunction

  // One phase of a written byte; the ninth bit releases SDA and samples the acknowledge.
  function automatic logic byte_out_tick(input logic sda_in);
    logic bitv;
    bitv = (bus_bits < i2c_rrm_pkg::BITS_PER_BYTE) ? bus_shift[7] : 1'b1;
    if (bus_phase == 2'd0) begin
      set_lines(1'b0, bitv);
      bus_phase = 2'd1;
      return 1'b0;
    end
    set_lines(1'b1, bitv);
    bus_phase = 2'd0;
    if (bus_bits >= i2c_rrm_pkg::BITS_PER_BYTE) begin
      if (sda_in)
        bus_nack = 1'b1;
      return 1'b1;
    end
    bus_shift = {bus_shift[6:0], 1'b0};
    bus_bits = bus_bits + 4'd1;
    return 1'b0;
  endfunction

  function automatic i2c_rrm_pkg::result_t next_bus_result(input i2c_rrm_pkg::mode_t mode,
                                                           input logic [7:0] reg_addr,
                                                           input logic sda_in);
    i2c_rrm_pkg::result_t res;
    logic                 valid;
    valid = 1'b0;
    if (mode == i2c_rrm_pkg::MODE_REQUEST) begin
      if (bus_step == i2c_rrm_pkg::STEP_IDLE) begin
        bus_reg = reg_addr;
        bus_nack = 1'b0;
        enter_step(i2c_rrm_pkg::STEP_START, 8'h00);
      end
    end else begin
      case (bus_step)
        i2c_rrm_pkg::STEP_START:
          if (start_cond_tick())
            enter_step(i2c_rrm_pkg::STEP_DEV_W, {bus_dev, 1'b0});
        i2c_rrm_pkg::STEP_DEV_W:
          if (byte_out_tick(sda_in))
            enter_step(i2c_rrm_pkg::STEP_REG, bus_reg);
        i2c_rrm_pkg::STEP_REG:
          if (byte_out_tick(sda_in))
            enter_step(i2c_rrm_pkg::STEP_RESTART, 8'h00);
        i2c_rrm_pkg::STEP_RESTART:
          if (start_cond_tick())
            enter_step(i2c_rrm_pkg::STEP_DEV_R, {bus_dev, 1'b1});
        i2c_rrm_pkg::STEP_DEV_R:
          if (byte_out_tick(sda_in))
            enter_step(i2c_rrm_pkg::STEP_READ, 8'h00);
        i2c_rrm_pkg::STEP_READ: begin
          if (bus_phase == 2'd0) begin
            set_lines(1'b0, 1'b1);
            bus_phase = 2'd1;
          end else begin
            set_lines(1'b1, 1'b1);
            bus_phase = 2'd0;
            bus_shift = {bus_shift[6:0], sda_in};
            bus_bits = bus_bits + 4'd1;
            if (bus_bits >= i2c_rrm_pkg::BITS_PER_BYTE) begin
              bus_step = i2c_rrm_pkg::STEP_NACK;
              bus_bits = '0;
            end
          end
        end
        i2c_rrm_pkg::STEP_NACK: begin
          if (bus_phase == 2'd0) begin
            set_lines(1'b0, 1'b1);
            bus_phase = 2'd1;
          end else begin
            set_lines(1'b1, 1'b1);
            bus_phase = 2'd0;
            bus_step = i2c_rrm_pkg::STEP_STOP;
          end
        end
        i2c_rrm_pkg::STEP_STOP: begin
          if (bus_phase == 2'd0) begin
            set_lines(1'b0, 1'b0);
            bus_phase = 2'd1;
          end else if (bus_phase == 2'd1) begin
            set_lines(1'b1, 1'b0);
            bus_phase = 2'd2;
          end else begin
            set_lines(1'b1, 1'b1);
            bus_phase = 2'd0;
            bus_step = i2c_rrm_pkg::STEP_IDLE;
            valid = 1'b1;
          end
        end
        default: begin
          bus_step = i2c_rrm_pkg::STEP_IDLE;
          bus_phase = '0;
          bus_bits = '0;
          set_lines(1'b1, 1'b1);
        end
      endcase
    end
    res.scl_out = bus_scl;
    res.sda_out = bus_sda;
    res.busy_res = (bus_step != i2c_rrm_pkg::STEP_IDLE);
    res.data_valid = valid;
    res.read_data = valid ? bus_shift : 8'h00;
    res.ack_error = bus_nack;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Sends one transaction in bursts with random gaps, then records what it should produce.
  task automatic send_item(input i2c_rrm_pkg::mode_t mode, input logic [7:0] reg_addr,
                           input logic sda_in, input logic use_typed,
                           input i2c_rrm_pkg::result_t typed_res);
    int                   gap;
    i2c_rrm_pkg::result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, sda_in, reg_addr};
    s_axis_tuser <= mode;
    do @(posedge clk); while (!s_axis_tready);
    predicted = next_bus_result(mode, reg_addr, sda_in);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls follow styles that are picked anew at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_style = $urandom_range(0, 3);
        ready_left = $urandom_range(10, 80);
      end else begin
        ready_left--;
      end
      case (ready_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    i2c_rrm_pkg::result_t got;
    i2c_rrm_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = i2c_rrm_pkg::result_t'(m_axis_tdata[12:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(m_axis_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.scl_out !== want.scl_out)
          report_mismatch("scl_out", 32'(got.scl_out), 32'(want.scl_out));
        if (got.sda_out !== want.sda_out)
          report_mismatch("sda_out", 32'(got.sda_out), 32'(want.sda_out));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.data_valid !== want.data_valid)
          report_mismatch("data_valid", 32'(got.data_valid), 32'(want.data_valid));
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
        if (got.ack_error !== want.ack_error)
          report_mismatch("ack_error", 32'(got.ack_error), 32'(want.ack_error));
        if (m_axis_tdata[i2c_rrm_pkg::TDATA_OUT_W-1:13] !== '0)
          report_mismatch("tdata padding",
                          32'(m_axis_tdata[i2c_rrm_pkg::TDATA_OUT_W-1:13]), 0);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    i2c_rrm_pkg::result_t               want;
    i2c_rrm_pkg::result_t               none;
    i2c_rrm_pkg::mode_t                 md;
    logic [7:0]                         ra;
    logic                               sd;
    logic [i2c_rrm_pkg::DEV_ADDR_W-1:0] new_dev;
    int                                 ph;
    int                                 n;

    none = '0;
    bus_step = i2c_rrm_pkg::STEP_IDLE;
    bus_bits = '0;
    bus_phase = '0;
    bus_shift = '0;
    bus_reg = '0;
    bus_nack = 1'b0;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    bus_dev = i2c_rrm_pkg::DEV_ADDR_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < 26; n++) begin
      want = '0;
      want.scl_out = dir_rows[n].e_scl;
      want.sda_out = dir_rows[n].e_sda;
      want.busy_res = dir_rows[n].e_busy;
      send_item(dir_rows[n].mode, dir_rows[n].reg_addr, dir_rows[n].sda_in,
                dir_rows[n].typed, want);
    end

    // The first random phase keeps the reset device address; later phases rewrite it.
    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_all_results();
        case (ph)
          1: new_dev = '0;
          2: new_dev = '1;
          4: new_dev = i2c_rrm_pkg::DEV_ADDR_RESET;
          default: new_dev = i2c_rrm_pkg::DEV_ADDR_W'($urandom_range(0, 127));
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= new_dev;
        bus_dev = new_dev;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      for (n = 0; n < 255; n++) begin
        ra = 8'($urandom);
        sd = 1'($urandom);
        if ($urandom_range(0, 7) == 0)
          ra = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        if (bus_step == i2c_rrm_pkg::STEP_IDLE) begin
          md = ($urandom_range(0, 9) < 8) ? i2c_rrm_pkg::MODE_REQUEST : i2c_rrm_pkg::MODE_TICK;
        end else begin
          md = ($urandom_range(0, 39) == 0) ? i2c_rrm_pkg::MODE_REQUEST
                                            : i2c_rrm_pkg::MODE_TICK;
          // Targets mostly acknowledge; a missing acknowledge stays the exception.
          if (bus_bits == i2c_rrm_pkg::BITS_PER_BYTE &&
              (bus_step == i2c_rrm_pkg::STEP_DEV_W || bus_step == i2c_rrm_pkg::STEP_REG ||
               bus_step == i2c_rrm_pkg::STEP_DEV_R))
            sd = ($urandom_range(0, 5) == 0);
        end
        send_item(md, ra, sd, 1'b0, none);
        if ($urandom_range(0, 199) == 0)
          wait_all_results();
      end
      while (bus_step != i2c_rrm_pkg::STEP_IDLE)
        send_item(i2c_rrm_pkg::MODE_TICK, 8'($urandom), 1'($urandom), 1'b0, none);
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
